// ===== rtl/ret_pkg.sv =====
// Package for the rotary encoder position tracker.
// Holds the item structs, the configuration struct and the register indexes.
// No dependencies.
package ret_pkg;

   localparam int unsigned CSR_ADDR_W = 4;

   localparam logic [1:0] REG_LOCKOUT     = 2'd0;
   localparam logic [1:0] REG_RANGE_LOW   = 2'd1;
   localparam logic [1:0] REG_RANGE_HIGH  = 2'd2;
   localparam logic [1:0] REG_START_POS   = 2'd3;

   localparam logic [15:0] LOCKOUT_RESET   = 16'd1000;
   localparam logic [15:0] RANGE_LOW_RESET = 16'h8000;
   localparam logic [15:0] RANGE_HIGH_RESET = 16'h7fff;
   localparam logic [15:0] START_POS_RESET = 16'h0000;

   typedef struct packed {
      logic [31:0] time_us;
      logic        pin_a;
      logic        pin_b;
      logic        switch_level;
      logic        clear_push;
   } req_type;

   typedef struct packed {
      logic signed [15:0] position;
      logic               changed;
      logic               pushed;
   } rsp_type;

   typedef struct packed {
      logic        [15:0] lockout_us;
      logic signed [15:0] range_low;
      logic signed [15:0] range_high;
   } cfg_type;

   typedef struct packed {
      logic               load;
      logic signed [15:0] value;
   } start_load_type;

endpackage

// ===== rtl/ret_csr.sv =====
// Configuration registers of the rotary encoder position tracker.
// APB-style write/read port; issues a load pulse on a start position write.
// Depends on ret_pkg.
module ret_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ret_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output ret_pkg::cfg_type                cfg,
   output ret_pkg::start_load_type         start_load
);

   logic [15:0] lockout_ff;
   logic [15:0] range_low_ff;
   logic [15:0] range_high_ff;
   logic [15:0] start_pos_ff;
   logic        wr_en;
   logic [1:0]  wr_idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign wr_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff    <= ret_pkg::LOCKOUT_RESET;
         range_low_ff  <= ret_pkg::RANGE_LOW_RESET;
         range_high_ff <= ret_pkg::RANGE_HIGH_RESET;
         start_pos_ff  <= ret_pkg::START_POS_RESET;
      end else if (wr_en) begin
         case (wr_idx)
            ret_pkg::REG_LOCKOUT:    lockout_ff    <= pwdata[15:0];
            ret_pkg::REG_RANGE_LOW:  range_low_ff  <= pwdata[15:0];
            ret_pkg::REG_RANGE_HIGH: range_high_ff <= pwdata[15:0];
            ret_pkg::REG_START_POS:  start_pos_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         ret_pkg::REG_LOCKOUT:    prdata = {16'd0, lockout_ff};
         ret_pkg::REG_RANGE_LOW:  prdata = {16'd0, range_low_ff};
         ret_pkg::REG_RANGE_HIGH: prdata = {16'd0, range_high_ff};
         ret_pkg::REG_START_POS:  prdata = {16'd0, start_pos_ff};
         default:                 prdata = 32'd0;
      endcase
   end

   assign cfg.lockout_us  = lockout_ff;
   assign cfg.range_low   = $signed(range_low_ff);
   assign cfg.range_high  = $signed(range_high_ff);

   assign start_load.load  = wr_en && (wr_idx == ret_pkg::REG_START_POS);
   assign start_load.value = $signed(pwdata[15:0]);

endmodule

// ===== rtl/ret_core.sv =====
// Decode core: lockout filter per pin, half-step counter with wrap,
// position follow, push flag and change report. Depends on ret_pkg.
module ret_core (
   input  logic                     clock,
   input  logic                     reset,
   input  ret_pkg::cfg_type         cfg,
   input  ret_pkg::start_load_type  start_load,
   input  logic                     step,
   input  ret_pkg::req_type         item,
   output ret_pkg::rsp_type         result
);

   logic               sa_prev_ff, sa_prev_in;
   logic               sb_prev_ff, sb_prev_in;
   logic               sig_a_ff, sig_a_in;
   logic               sig_b_ff, sig_b_in;
   logic [31:0]        acc_a_ff, acc_a_in;
   logic [31:0]        acc_b_ff, acc_b_in;
   logic signed [17:0] half_ff, half_in;
   logic signed [15:0] last_pos_ff, last_pos_in;
   logic signed [15:0] rep_pos_ff, rep_pos_in;
   logic               sw_prev_ff, sw_prev_in;
   logic               push_ff, push_in;

   logic [31:0]        delta_a;
   logic [31:0]        delta_b;
   logic               evt_a;
   logic               evt_b;
   logic signed [17:0] lo_w;
   logic signed [17:0] hi_w;
   logic signed [17:0] stepped;
   logic signed [17:0] wrapped;
   logic               changed;

   assign delta_a = item.time_us - acc_a_ff;
   assign delta_b = item.time_us - acc_b_ff;
   assign evt_a = (item.pin_a != sa_prev_ff) && (delta_a >= {16'd0, cfg.lockout_us})
                  && (item.pin_a != sig_a_ff);
   assign evt_b = (item.pin_b != sb_prev_ff) && (delta_b >= {16'd0, cfg.lockout_us})
                  && (item.pin_b != sig_b_ff);

   assign lo_w = $signed({cfg.range_low[15], cfg.range_low, 1'b0});
   assign hi_w = $signed({cfg.range_high[15], cfg.range_high, 1'b0});

   // count direction uses the B level accepted before this item
   assign stepped = (item.pin_a == sig_b_ff) ? half_ff + 18'sd1 : half_ff - 18'sd1;

   always_comb begin
      if (stepped >= hi_w + 18'sd2) begin
         wrapped = lo_w;
      end else if (stepped <= lo_w - 18'sd2) begin
         wrapped = hi_w;
      end else begin
         wrapped = stepped;
      end
   end

   always_comb begin
      push_in    = (item.clear_push ? 1'b0 : push_ff) | (sw_prev_ff & ~item.switch_level);
      sw_prev_in = item.switch_level;
      sa_prev_in = item.pin_a;
      sb_prev_in = item.pin_b;
      sig_a_in   = evt_a ? item.pin_a : sig_a_ff;
      acc_a_in   = evt_a ? item.time_us : acc_a_ff;
      sig_b_in   = evt_b ? item.pin_b : sig_b_ff;
      acc_b_in   = evt_b ? item.time_us : acc_b_ff;
      half_in    = evt_a ? wrapped : half_ff;
      last_pos_in = half_in[0] ? last_pos_ff : $signed(half_in[16:1]);
      changed    = (last_pos_in != rep_pos_ff) ? 1'b1 : push_in;
      rep_pos_in = last_pos_in;
   end

   assign result.position = last_pos_in;
   assign result.changed  = changed;
   assign result.pushed   = push_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_prev_ff  <= 1'b0;
         sb_prev_ff  <= 1'b0;
         sig_a_ff    <= 1'b1;
         sig_b_ff    <= 1'b1;
         acc_a_ff    <= 32'd0;
         acc_b_ff    <= 32'd0;
         half_ff     <= 18'sd0;
         last_pos_ff <= 16'sd0;
         rep_pos_ff  <= 16'sd0;
         sw_prev_ff  <= 1'b1;
         push_ff     <= 1'b0;
      end else if (start_load.load) begin
         half_ff     <= $signed({start_load.value[15], start_load.value, 1'b0});
         last_pos_ff <= start_load.value;
      end else if (step) begin
         sa_prev_ff  <= sa_prev_in;
         sb_prev_ff  <= sb_prev_in;
         sig_a_ff    <= sig_a_in;
         sig_b_ff    <= sig_b_in;
         acc_a_ff    <= acc_a_in;
         acc_b_ff    <= acc_b_in;
         half_ff     <= half_in;
         last_pos_ff <= last_pos_in;
         rep_pos_ff  <= rep_pos_in;
         sw_prev_ff  <= sw_prev_in;
         push_ff     <= push_in;
      end
   end

endmodule

// ===== rtl/rotary_encoder_position_tracker_top.sv =====
// Top level of the rotary encoder position tracker.
// Input register, decode core, result register and configuration registers.
// Depends on ret_pkg, ret_csr and ret_core.
//
// Usage:
//   req_* carries one encoder sample per item (time, pins A/B, switch, clear).
//   rsp_* returns one item per sample: position, changed and pushed.
//   An item moves on a channel at a clock edge with valid high and stall low.
//   Each item is held in the input register; the decode logic then writes the
//   result register, which drives rsp_*. Throughput is one item per cycle while
//   rsp_stall stays low; the decoder state updates as an item leaves the input
//   register, so the next item sees it right away.
//   When rsp_stall holds a waiting result, one more item may still enter the
//   input register; req_stall rises only while both registers are full.
//   Reset (synchronous) empties both registers, restores the register
//   defaults and the decoder state. Configuration writes complete in the
//   access cycle (pready is tied high); write only while no item is in flight.
module rotary_encoder_position_tracker_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  ret_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ret_pkg::rsp_type                rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ret_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   ret_pkg::cfg_type        cfg;
   ret_pkg::start_load_type start_load;
   ret_pkg::req_type        in_data_ff;
   ret_pkg::rsp_type        result;
   ret_pkg::rsp_type        out_data_ff;
   logic                    in_valid_ff;
   logic                    out_valid_ff;
   logic                    out_ready;
   logic                    advance;
   logic                    in_ready;

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign in_ready  = !in_valid_ff || out_ready;
   assign req_stall = !in_ready;

   ret_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .cfg        (cfg),
      .start_load (start_load)
   );

   ret_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .start_load (start_load),
      .step       (advance),
      .item       (in_data_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_ready) begin
            out_valid_ff <= advance;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_valid) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== rtl/ret_checker.sv =====
// Port-level checks for the rotary encoder position tracker.
// Bound to rotary_encoder_position_tracker_top; depends on ret_pkg.
module ret_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ret_pkg::rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled item changed");

   a_push_reports_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.pushed |-> rsp_data.changed)
      else $error("pending push without changed");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a blocked result");

endmodule

bind rotary_encoder_position_tracker_top ret_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/ret_tb_pkg.sv =====
// Scoreboard for the rotary encoder position tracker testbench.
// Tracks encoder state per accepted sample and checks each result item in order.
// Depends on ret_pkg.
package ret_tb_pkg;

   class position_scoreboard;
      logic        [15:0] lockout_us;
      logic signed [15:0] range_low;
      logic signed [15:0] range_high;
      logic               a_prev, b_prev, a_level, b_level;
      logic               switch_prev, push_pending;
      logic        [31:0] a_accept_time, b_accept_time;
      int                 half_steps;
      logic signed [15:0] last_position, reported_position;
      ret_pkg::rsp_type   expected_reports[$];
      int                 mismatches;
      int                 checked;

      function new();
         lockout_us        = ret_pkg::LOCKOUT_RESET;
         range_low         = ret_pkg::RANGE_LOW_RESET;
         range_high        = ret_pkg::RANGE_HIGH_RESET;
         a_prev            = 1'b0;
         b_prev            = 1'b0;
         a_level           = 1'b1;
         b_level           = 1'b1;
         switch_prev       = 1'b1;
         push_pending      = 1'b0;
         a_accept_time     = '0;
         b_accept_time     = '0;
         half_steps        = 0;
         last_position     = ret_pkg::START_POS_RESET;
         reported_position = '0;
         mismatches        = 0;
         checked           = 0;
      endfunction

      function void note_config(logic [1:0] index, logic [15:0] value);
         case (index)
            ret_pkg::REG_LOCKOUT: lockout_us = value;
            ret_pkg::REG_RANGE_LOW: range_low = value;
            ret_pkg::REG_RANGE_HIGH: range_high = value;
            ret_pkg::REG_START_POS: begin
               half_steps    = 2 * int'($signed(value));
               last_position = value;
            end
            default: ;
         endcase
      endfunction

      // Predict the result item for one accepted encoder sample.
      function void track_sample(ret_pkg::req_type s);
         int               lo, hi;
         logic [31:0]      dt;
         ret_pkg::rsp_type want;
         lo = 2 * int'(range_low);
         hi = 2 * int'(range_high);
         if (s.clear_push)
            push_pending = 1'b0;
         if (switch_prev && !s.switch_level)
            push_pending = 1'b1;
         switch_prev = s.switch_level;

         dt = s.time_us - a_accept_time;
         if (s.pin_a != a_prev && dt >= {16'h0, lockout_us} && s.pin_a != a_level) begin
            a_level       = s.pin_a;
            a_accept_time = s.time_us;
            half_steps    = half_steps + ((a_level == b_level) ? 1 : -1);
            if (half_steps >= hi + 2)
               half_steps = lo;
            if (half_steps <= lo - 2)
               half_steps = hi;
         end
         a_prev = s.pin_a;

         dt = s.time_us - b_accept_time;
         if (s.pin_b != b_prev && dt >= {16'h0, lockout_us} && s.pin_b != b_level) begin
            b_level       = s.pin_b;
            b_accept_time = s.time_us;
         end
         b_prev = s.pin_b;

         if (half_steps[0] == 1'b0)
            last_position = half_steps[16:1];

         want.position = last_position;
         if (last_position != reported_position) begin
            reported_position = last_position;
            want.changed      = 1'b1;
         end else begin
            want.changed = push_pending;
         end
         want.pushed = push_pending;
         expected_reports.push_back(want);
      endfunction

      function void check_report(ret_pkg::rsp_type got);
         ret_pkg::rsp_type want;
         checked++;
         if (expected_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result item %0d with nothing expected: pos=%0d chg=%0b push=%0b",
                        checked, got.position, got.changed, got.pushed);
            return;
         end
         want = expected_reports.pop_front();
         if (got.position !== want.position || got.changed !== want.changed ||
             got.pushed !== want.pushed) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"result item %0d: expected pos=%0d chg=%0b push=%0b, ",
                         "got pos=%0d chg=%0b push=%0b"},
                        checked, want.position, want.changed, want.pushed,
                        got.position, got.changed, got.pushed);
         end
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction
   endclass

endpackage

// ===== tb/tb_top.sv =====
// Testbench top for the rotary encoder position tracker.
// Directed and random encoder samples over several register settings, random stalls.
// Depends on ret_pkg, ret_tb_pkg and rotary_encoder_position_tracker_top.
module tb_top;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 180;
   localparam int HOLD_AT_ITEM   = 400;
   localparam int HOLD_CYCLES    = 200;

   typedef enum int {MODE_QUAD, MODE_BOUNCE, MODE_NOISE} stim_mode_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   ret_pkg::req_type               req_data;
   logic                           rsp_valid;
   logic                           rsp_stall;
   ret_pkg::rsp_type               rsp_data;
   logic                           psel, penable, pwrite, pready;
   logic [ret_pkg::CSR_ADDR_W-1:0] paddr;
   logic [31:0]                    pwdata, prdata;

   ret_tb_pkg::position_scoreboard board = new();

   logic [31:0] cur_time;
   logic        cur_a, cur_b, cur_sw;
   int          items_accepted;
   int          idle_cycles;
   bit          long_hold;

   logic        [15:0] phase_lock  [6] = '{16'd0, 16'd65535, 16'd3, 16'd10, 16'd20, 16'd1};
   logic signed [15:0] phase_lo    [6] = '{16'h8000, 16'h8000, -16'sd2, 16'sd5, -16'sd3, 16'sd0};
   logic signed [15:0] phase_hi    [6] = '{16'h7fff, 16'h7fff, 16'sd2, -16'sd5, 16'sd3, 16'sd0};
   logic signed [15:0] phase_start [6] = '{16'h7fff, 16'h8000, 16'sd0, 16'sd0, 16'sd100, 16'sd0};

   rotary_encoder_position_tracker_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock     = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
   end

   always #5 clock = ~clock;

   function automatic ret_pkg::req_type sample(logic [31:0] t, logic a, logic b, logic sw,
                                               logic clr);
      ret_pkg::req_type s;
      s.time_us      = t;
      s.pin_a        = a;
      s.pin_b        = b;
      s.switch_level = sw;
      s.clear_push   = clr;
      return s;
   endfunction

   task automatic send_item(ret_pkg::req_type s, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      board.track_sample(s);
      items_accepted++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, logic [15:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= {{16{value[15]}}, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      board.note_config(index, value);
   endtask

   task automatic apply_settings(logic [15:0] lock, logic [15:0] lo, logic [15:0] hi,
                                 logic [15:0] start);
      wait_drained();
      csr_write(ret_pkg::REG_LOCKOUT, lock);
      csr_write(ret_pkg::REG_RANGE_LOW, lo);
      csr_write(ret_pkg::REG_RANGE_HIGH, hi);
      csr_write(ret_pkg::REG_START_POS, start);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Bursts of clean quadrature steps, contact bounce and random noise.
   task automatic feed_random(int count);
      int            n, burst_left, pick, gap;
      bit            busy_burst;
      logic [1:0]    dir, quad;
      logic [31:0]   span;
      stim_mode_type mode;
      burst_left = 0;
      busy_burst = 1'b0;
      dir        = 2'd1;
      mode       = MODE_QUAD;
      for (n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            pick       = $urandom_range(0, 99);
            mode       = pick < 70 ? MODE_QUAD : (pick < 85 ? MODE_BOUNCE : MODE_NOISE);
            dir        = $urandom_range(0, 1) ? 2'd1 : 2'd3;
            busy_burst = ($urandom_range(0, 3) == 0);
         end
         burst_left--;
         span = {16'h0, board.lockout_us};
         case (mode)
            MODE_QUAD: begin
               quad  = {cur_a, cur_a ^ cur_b} + dir;
               cur_a = quad[1];
               cur_b = quad[1] ^ quad[0];
               if ($urandom_range(0, 4) != 0)
                  cur_time = cur_time + span + $urandom_range(0, span / 2 + 3);
               else
                  cur_time = cur_time + $urandom_range(0, span);
            end
            MODE_BOUNCE: begin
               if ($urandom_range(0, 1))
                  cur_a = ~cur_a;
               else
                  cur_b = ~cur_b;
               cur_time = cur_time + $urandom_range(0, span / 4 + 1);
            end
            default: begin
               cur_a = 1'($urandom_range(0, 1));
               cur_b = 1'($urandom_range(0, 1));
               if ($urandom_range(0, 1))
                  cur_time = $urandom;
               else
                  cur_time = cur_time + $urandom_range(0, 2 * span + 2);
            end
         endcase
         if ($urandom_range(0, 11) == 0)
            cur_sw = ~cur_sw;
         pick = $urandom_range(0, 99);
         if (busy_burst || long_hold || pick < 70)
            gap = 0;
         else if (pick < 95)
            gap = $urandom_range(1, 3);
         else
            gap = $urandom_range(8, 40);
         send_item(sample(cur_time, cur_a, cur_b, cur_sw, $urandom_range(0, 9) == 0), gap);
      end
   endtask

   initial begin : stimulus
      int                 p;
      logic        [15:0] rnd_lock;
      logic signed [15:0] rnd_lo;
      items_accepted = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: lockout 1000, full range
      send_item(sample(32'd0, 1'b0, 1'b0, 1'b1, 1'b0), 0);
      send_item(sample(32'd10, 1'b1, 1'b0, 1'b1, 1'b0), 0);       // bounce inside lockout
      send_item(sample(32'd1500, 1'b0, 1'b0, 1'b1, 1'b0), 1);
      send_item(sample(32'd2600, 1'b0, 1'b1, 1'b0, 1'b0), 0);     // press
      send_item(sample(32'd3700, 1'b1, 1'b1, 1'b0, 1'b0), 0);
      send_item(sample(32'd4800, 1'b1, 1'b0, 1'b1, 1'b1), 0);     // release, clear
      send_item(sample(32'd5900, 1'b0, 1'b0, 1'b0, 1'b1), 2);     // clear and press together
      send_item(sample(32'd7000, 1'b0, 1'b1, 1'b0, 1'b0), 0);
      send_item(sample(32'd7100, 1'b1, 1'b1, 1'b0, 1'b1), 0);
      send_item(sample(32'hffff_fe00, 1'b1, 1'b0, 1'b1, 1'b1), 0);
      send_item(sample(32'h0000_0100, 1'b0, 1'b0, 1'b1, 1'b0), 0); // time wraps
      send_item(sample(32'hffff_ffff, 1'b1, 1'b1, 1'b0, 1'b0), 0);
      send_item(sample(32'h0000_0001, 1'b0, 1'b1, 1'b1, 1'b0), 0);
      send_item(sample(32'haaaa_5555, 1'b0, 1'b0, 1'b1, 1'b0), 0);
      send_item(sample(32'h5555_aaaa, 1'b1, 1'b0, 1'b0, 1'b1), 0);
      cur_time = 32'h5555_aaaa;
      cur_a    = 1'b1;
      cur_b    = 1'b0;
      cur_sw   = 1'b0;
      feed_random(PHASE_ITEMS);

      for (p = 0; p < 7; p++) begin
         if (p < 6) begin
            apply_settings(phase_lock[p], phase_lo[p], phase_hi[p], phase_start[p]);
         end else begin
            rnd_lock = 16'($urandom_range(0, 2000));
            rnd_lo   = 16'($urandom_range(0, 65535));
            apply_settings(rnd_lock, rnd_lo, 16'(rnd_lo + $urandom_range(0, 20)),
                           16'(rnd_lo + $urandom_range(0, 10)));
         end
         feed_random(PHASE_ITEMS);
      end

      wait_drained();
      if (board.mismatches == 0 && board.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin : result_side
      int pick, len;
      bit hold_done;
      long_hold = 1'b0;
      hold_done = 1'b0;
      while (reset)
         @(posedge clock);
      forever begin
         if (!hold_done && items_accepted >= HOLD_AT_ITEM) begin
            hold_done = 1'b1;
            long_hold = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               rsp_stall <= 1'b0;
               len = $urandom_range(1, 20);
            end else if (pick < 60) begin
               rsp_stall <= 1'b0;
               len = $urandom_range(40, 150);
            end else if (pick < 88) begin
               rsp_stall <= 1'b1;
               len = $urandom_range(1, 3);
            end else if (pick < 97) begin
               rsp_stall <= 1'b1;
               len = $urandom_range(4, 12);
            end else begin
               rsp_stall <= 1'b1;
               len = $urandom_range(20, 60);
            end
            repeat (len) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_report(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ===== rotary_encoder_position_tracker_top.f =====
rtl/ret_pkg.sv
rtl/ret_csr.sv
rtl/ret_core.sv
rtl/rotary_encoder_position_tracker_top.sv
rtl/ret_checker.sv
tb/ret_tb_pkg.sv
tb/tb_top.sv
